/* hw/rtl/tocw_pkg.sv */
// Shared types, codes and the 5x7 font table for the OLED text column writer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tocw_pkg;

   localparam int GLYPH_WIDTH = 5;

   // Input commands
   localparam logic CMD_PRINT      = 1'b0;
   localparam logic CMD_SET_CURSOR = 1'b1;

   // Display controller command bytes and character codes
   localparam logic [7:0] OP_COLUMN_ADDR   = 8'h21;
   localparam logic [7:0] OP_PAGE_ADDR     = 8'h22;
   localparam logic [7:0] CODE_SPACE       = 8'h20;
   localparam logic [7:0] CODE_NEWLINE     = 8'h0A;
   localparam logic [7:0] CODE_LAST_PRINT  = 8'h7E;
   localparam logic [7:0] SPACER_BYTE      = 8'h00;

   // Byte positions within one job: window command, glyph columns, spacer
   localparam logic [3:0] STEP_OP_COLUMN   = 4'd0;
   localparam logic [3:0] STEP_COLUMN      = 4'd1;
   localparam logic [3:0] STEP_COLUMN_END  = 4'd2;
   localparam logic [3:0] STEP_OP_PAGE     = 4'd3;
   localparam logic [3:0] STEP_PAGE        = 4'd4;
   localparam logic [3:0] STEP_PAGE_END    = 4'd5;
   localparam logic [3:0] STEP_GLYPH_FIRST = 4'd6;
   localparam logic [3:0] STEP_GLYPH_LAST  = 4'd10;
   localparam logic [3:0] STEP_SPACER      = 4'd11;

   typedef struct packed {
      logic       window;   // send the column/page window command first
      logic [7:0] column;   // window start column
      logic [2:0] page;     // window start page
      logic       glyph;    // send glyph columns and spacer
      logic [6:0] index;    // font table row
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Five font columns of one glyph, first column in the top byte
   function automatic logic [39:0] glyph_columns(input logic [6:0] index);
      logic [39:0] word;
      case (index)
         7'd0:  word = 40'h0000000000;
         7'd1:  word = 40'h00002f0000;
         7'd2:  word = 40'h0007000700;
         7'd3:  word = 40'h147f147f14;
         7'd4:  word = 40'h242a7f2a12;
         7'd5:  word = 40'h2313086462;
         7'd6:  word = 40'h3649552250;
         7'd7:  word = 40'h0005030000;
         7'd8:  word = 40'h001c224100;
         7'd9:  word = 40'h0041221c00;
         7'd10: word = 40'h14083e0814;
         7'd11: word = 40'h08083e0808;
         7'd12: word = 40'h0000a06000;
         7'd13: word = 40'h0808080808;
         7'd14: word = 40'h0060600000;
         7'd15: word = 40'h2010080402;
         7'd16: word = 40'h3e5149453e;
         7'd17: word = 40'h00427f4000;
         7'd18: word = 40'h4261514946;
         7'd19: word = 40'h2141454b31;
         7'd20: word = 40'h1814127f10;
         7'd21: word = 40'h2745454539;
         7'd22: word = 40'h3c4a494930;
         7'd23: word = 40'h0171090503;
         7'd24: word = 40'h3649494936;
         7'd25: word = 40'h064949291e;
         7'd26: word = 40'h0036360000;
         7'd27: word = 40'h0056360000;
         7'd28: word = 40'h0814224100;
         7'd29: word = 40'h1414141414;
         7'd30: word = 40'h0041221408;
         7'd31: word = 40'h0201510906;
         7'd32: word = 40'h324959513e;
         7'd33: word = 40'h7c1211127c;
         7'd34: word = 40'h7f49494936;
         7'd35: word = 40'h3e41414122;
         7'd36: word = 40'h7f4141221c;
         7'd37: word = 40'h7f49494941;
         7'd38: word = 40'h7f09090901;
         7'd39: word = 40'h3e4149497a;
         7'd40: word = 40'h7f0808087f;
         7'd41: word = 40'h00417f4100;
         7'd42: word = 40'h2040413f01;
         7'd43: word = 40'h7f08142241;
         7'd44: word = 40'h7f40404040;
         7'd45: word = 40'h7f020c027f;
         7'd46: word = 40'h7f0408107f;
         7'd47: word = 40'h3e4141413e;
         7'd48: word = 40'h7f09090906;
         7'd49: word = 40'h3e4151215e;
         7'd50: word = 40'h7f09192946;
         7'd51: word = 40'h4649494931;
         7'd52: word = 40'h01017f0101;
         7'd53: word = 40'h3f4040403f;
         7'd54: word = 40'h1f2040201f;
         7'd55: word = 40'h3f4038403f;
         7'd56: word = 40'h6314081463;
         7'd57: word = 40'h0708700807;
         7'd58: word = 40'h6151494543;
         7'd59: word = 40'h007f414100;
         7'd60: word = 40'h55aa55aa55;
         7'd61: word = 40'h0041417f00;
         7'd62: word = 40'h0402010204;
         7'd63: word = 40'h4040404040;
         7'd64: word = 40'h0003050000;
         7'd65: word = 40'h2054545478;
         7'd66: word = 40'h7f48444438;
         7'd67: word = 40'h3844444420;
         7'd68: word = 40'h384444487f;
         7'd69: word = 40'h3854545418;
         7'd70: word = 40'h087e090102;
         7'd71: word = 40'h18a4a4a47c;
         7'd72: word = 40'h7f08040478;
         7'd73: word = 40'h00447d4000;
         7'd74: word = 40'h4080847d00;
         7'd75: word = 40'h7f10284400;
         7'd76: word = 40'h00417f4000;
         7'd77: word = 40'h7c04180478;
         7'd78: word = 40'h7c08040478;
         7'd79: word = 40'h3844444438;
         7'd80: word = 40'hfc24242418;
         7'd81: word = 40'h18242418fc;
         7'd82: word = 40'h7c08040408;
         7'd83: word = 40'h4854545420;
         7'd84: word = 40'h043f444020;
         7'd85: word = 40'h3c4040207c;
         7'd86: word = 40'h1c2040201c;
         7'd87: word = 40'h3c4030403c;
         7'd88: word = 40'h4428102844;
         7'd89: word = 40'h1ca0a0a07c;
         7'd90: word = 40'h4464544c44;
         7'd91: word = 40'h00107c8200;
         7'd92: word = 40'h0000ff0000;
         7'd93: word = 40'h00827c1000;
         7'd94: word = 40'h0006090906;
         default: word = 40'h0000000000;
      endcase
      return word;
   endfunction

endpackage

/* hw/rtl/tocw_front.sv */
// Front end: accepts print and set-cursor items, keeps the cursor and turns
// each item into a job for the byte sequencer. Uses tocw_pkg.
`timescale 1ns / 1ps

module tocw_front #(
   parameter int COLUMNS   = 128,
   parameter int LAST_PAGE = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic                req_cmd,
   input  logic [7:0]          req_char_code,
   input  logic [7:0]          req_page_number,
   input  logic [7:0]          req_column_number,
   input  tocw_pkg::queue_status_type queue_status,
   output logic                job_push,
   output tocw_pkg::job_type   job
);
   import tocw_pkg::*;

   logic [2:0] page_ff, page_in;
   logic [7:0] column_ff, column_in;
   logic       accept;
   logic       newline;
   logic       wrap;
   logic       printable;
   logic       cursor_ok;
   logic [2:0] next_page;

   assign accept    = req_push && !queue_status.full;
   assign newline   = (req_char_code == CODE_NEWLINE);
   assign wrap      = newline ||
                      (({1'b0, column_ff} + 9'(GLYPH_WIDTH)) >= 9'(COLUMNS));
   assign printable = req_char_code inside {[CODE_SPACE:CODE_LAST_PRINT]};
   assign cursor_ok = (req_page_number <= 8'(LAST_PAGE)) &&
                      ({1'b0, req_column_number} < 9'(COLUMNS));
   assign next_page = (page_ff >= 3'(LAST_PAGE)) ? 3'd0 : page_ff + 3'd1;

   always_comb begin
      page_in   = page_ff;
      column_in = column_ff;
      job       = '0;
      job_push  = 1'b0;
      if (req_cmd == CMD_SET_CURSOR) begin
         job.window = 1'b1;
         job.column = req_column_number;
         job.page   = req_page_number[2:0];
         if (accept && cursor_ok) begin
            job_push  = 1'b1;
            page_in   = req_page_number[2:0];
            column_in = req_column_number;
         end
      end else begin
         job.window = wrap;
         job.column = 8'd0;
         job.page   = next_page;
         job.glyph  = !newline;
         job.index  = printable ? 7'(req_char_code - CODE_SPACE) : 7'd0;
         if (accept) begin
            job_push = 1'b1;
            if (wrap) begin
               page_in = next_page;
            end
            // glyph plus spacer advances the column; a newline sets it to zero
            if (newline) begin
               column_in = 8'd0;
            end else begin
               column_in = (wrap ? 8'd0 : column_ff) + 8'(GLYPH_WIDTH + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff   <= '0;
         column_ff <= '0;
      end else begin
         page_ff   <= page_in;
         column_ff <= column_in;
      end
   end

endmodule

/* hw/rtl/tocw_queue.sv */
// Four-entry job queue between the front end and the byte sequencer.
// Uses tocw_pkg for the job and status types.
`timescale 1ns / 1ps

module tocw_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tocw_pkg::job_type          push_job,
   input  logic                       pop,
   output tocw_pkg::job_type          head_job,
   output tocw_pkg::queue_status_type status
);
   import tocw_pkg::*;

   localparam int DEPTH = 4;

   job_type    entries_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign status.empty = (count_ff == 3'd0);
   assign status.full  = (count_ff == 3'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + 3'(do_push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/tocw_back.sv */
// Byte sequencer: walks the head job through window command, glyph columns
// and spacer, one beat per cycle into the result register while the receiver pops. Uses tocw_pkg.
`timescale 1ns / 1ps

module tocw_back #(
   parameter int COLUMNS   = 128,
   parameter int LAST_PAGE = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tocw_pkg::job_type          head_job,
   input  tocw_pkg::queue_status_type queue_status,
   output logic                       job_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_is_command,
   output logic                       rsp_last
);
   import tocw_pkg::*;

   logic [3:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        command_ff, command_in;
   logic        last_ff, last_in;
   logic        advance;
   logic [3:0]  position;
   logic        final_beat;
   logic [39:0] glyph_word;
   logic [7:0]  beat_byte;

   assign advance    = !valid_ff || rsp_pop;
   // skip the window bytes when the job has no window command
   assign position   = head_job.window ? step_ff : step_ff + STEP_GLYPH_FIRST;
   assign final_beat = (position == (head_job.glyph ? STEP_SPACER : STEP_PAGE_END));
   assign glyph_word = glyph_columns(head_job.index);

   always_comb begin
      case (position)
         STEP_OP_COLUMN:        beat_byte = OP_COLUMN_ADDR;
         STEP_COLUMN:           beat_byte = head_job.column;
         STEP_COLUMN_END:       beat_byte = 8'(COLUMNS - 1);
         STEP_OP_PAGE:          beat_byte = OP_PAGE_ADDR;
         STEP_PAGE:             beat_byte = {5'd0, head_job.page};
         STEP_PAGE_END:         beat_byte = 8'(LAST_PAGE);
         STEP_GLYPH_FIRST:      beat_byte = glyph_word[39:32];
         STEP_GLYPH_FIRST + 4'd1: beat_byte = glyph_word[31:24];
         STEP_GLYPH_FIRST + 4'd2: beat_byte = glyph_word[23:16];
         STEP_GLYPH_FIRST + 4'd3: beat_byte = glyph_word[15:8];
         STEP_GLYPH_LAST:       beat_byte = glyph_word[7:0];
         default:               beat_byte = SPACER_BYTE;
      endcase
   end

   always_comb begin
      step_in    = step_ff;
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      command_in = command_ff;
      last_in    = last_ff;
      job_pop    = 1'b0;
      if (advance) begin
         valid_in = !queue_status.empty;
         if (!queue_status.empty) begin
            byte_in    = beat_byte;
            command_in = (position < STEP_GLYPH_FIRST);
            last_in    = final_beat;
            if (final_beat) begin
               job_pop = 1'b1;
               step_in = 4'd0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      command_ff <= command_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_command = command_ff;
   assign rsp_last       = last_ff;

endmodule

/* hw/rtl/text_to_oled_column_writer.sv */
// Text renderer for a page-addressed monochrome OLED controller.
// Input queue (req_push / req_full): one beat per character or cursor move.
//   req_cmd 0 prints req_char_code (0x0A is newline), 1 moves the cursor to
//   req_page_number / req_column_number; an out-of-range move is dropped.
// Result queue (rsp_empty / rsp_pop): one byte per beat with its DC flag
//   (rsp_is_command) and rsp_last on the final byte of each item.
// A print gives 6 data bytes (5 font columns and a blank column), preceded
//   by the 6-byte column/page window command when the line wraps; a newline
//   or cursor move gives the 6 command bytes alone.
// When the sequencer is idle, the first byte of an item passes through the job
//   queue and the result register before it becomes visible.
// The sequencer sends one byte per cycle while the receiver pops, one item at
//   a time; a four-job queue between the front end and the sequencer lets up
//   to four items be taken in consecutive cycles.
// When the receiver holds off pop, the result register holds its byte, the
//   job queue fills and req_full rises; nothing is lost.
// Reset clears the cursor to page 0, column 0 and empties both queues.
`timescale 1ns / 1ps

module text_to_oled_column_writer #(
   parameter int COLUMNS   = 128,
   parameter int LAST_PAGE = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_cmd,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_page_number,
   input  logic [7:0] req_column_number,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_command,
   output logic       rsp_last
);
   import tocw_pkg::*;

   job_type          new_job;
   job_type          head_job;
   queue_status_type queue_status;
   logic             job_push;
   logic             job_pop;

   assign req_full = queue_status.full;

   tocw_front #(
      .COLUMNS   (COLUMNS),
      .LAST_PAGE (LAST_PAGE)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_cmd           (req_cmd),
      .req_char_code     (req_char_code),
      .req_page_number   (req_page_number),
      .req_column_number (req_column_number),
      .queue_status      (queue_status),
      .job_push          (job_push),
      .job               (new_job)
   );

   tocw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (new_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   tocw_back #(
      .COLUMNS   (COLUMNS),
      .LAST_PAGE (LAST_PAGE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .queue_status   (queue_status),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last)
   );

endmodule

/* tb/sv/text_to_oled_column_writer_tb.sv */
// Self-checking testbench for the OLED text column writer: random and directed
// characters and cursor moves, each byte checked against an in-bench predictor.
// Depends on tocw_pkg and text_to_oled_column_writer.
`timescale 1ns / 1ps

module text_to_oled_column_writer_tb;
   import tocw_pkg::*;

   localparam int COLUMNS      = 128;
   localparam int LAST_PAGE    = 7;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_ITEMS   = 50;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;

   // Font columns, first column in the top byte
   localparam logic [39:0] FONT_ROWS [0:94] = '{
      40'h0000000000, 40'h00002f0000, 40'h0007000700,
      40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001c224100,
      40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0000a06000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
      40'h4261514946, 40'h2141454b31, 40'h1814127f10,
      40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000,
      40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324959513e,
      40'h7c1211127c, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
      40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
      40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
      40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
      40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
      40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
      40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h55aa55aa55, 40'h0041417f00, 40'h0402010204,
      40'h4040404040, 40'h0003050000, 40'h2054545478,
      40'h7f48444438, 40'h3844444420, 40'h384444487f,
      40'h3854545418, 40'h087e090102, 40'h18a4a4a47c,
      40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
      40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
      40'h7c08040478, 40'h3844444438, 40'hfc24242418,
      40'h18242418fc, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
      40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
      40'h4464544c44, 40'h00107c8200, 40'h0000ff0000,
      40'h00827c1000, 40'h0006090906
   };

   typedef struct {
      logic       cmd;
      logic [7:0] code;
      logic [7:0] page;
      logic [7:0] column;
   } text_item_type;

   typedef struct {
      logic [7:0] value;
      logic       is_command;
      logic       last;
   } display_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic       req_cmd = CMD_PRINT;
   logic [7:0] req_char_code = 8'h00;
   logic [7:0] req_page_number = 8'h00;
   logic [7:0] req_column_number = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_command;
   logic       rsp_last;

   text_item_type    pending_items [$];
   display_byte_type display_bytes [$];
   logic [2:0]       cursor_page = 3'd0;
   logic [7:0]       cursor_column = 8'd0;
   int               error_count = 0;
   int               items_taken = 0;
   int               push_gap = 0;
   int               pop_gap = 0;
   int               stalled_cycles = 0;
   logic             receiver_hold = 1'b0;

   text_to_oled_column_writer #(
      .COLUMNS   (COLUMNS),
      .LAST_PAGE (LAST_PAGE)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_char_code     (req_char_code),
      .req_page_number   (req_page_number),
      .req_column_number (req_column_number),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_command    (rsp_is_command),
      .rsp_last          (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("%0t ERROR: %s", $realtime, what);
   endtask

   function automatic void queue_byte(input logic [7:0] value, input logic is_command);
      display_byte_type b;
      b.value = value;
      b.is_command = is_command;
      b.last = 1'b0;
      display_bytes.push_back(b);
   endfunction

   function automatic void queue_window();
      queue_byte(OP_COLUMN_ADDR, 1'b1);
      queue_byte(cursor_column, 1'b1);
      queue_byte(8'(COLUMNS - 1), 1'b1);
      queue_byte(OP_PAGE_ADDR, 1'b1);
      queue_byte({5'd0, cursor_page}, 1'b1);
      queue_byte(8'(LAST_PAGE), 1'b1);
   endfunction

   // Update the cursor and queue the bytes that one accepted item produces
   function automatic void render_item(input text_item_type item);
      int          first = display_bytes.size();
      logic        newline;
      logic [39:0] columns;
      if (item.cmd == CMD_SET_CURSOR) begin
         if (item.page <= LAST_PAGE && item.column < COLUMNS) begin
            cursor_page = item.page[2:0];
            cursor_column = item.column;
            queue_window();
         end
      end else begin
         newline = (item.code == CODE_NEWLINE);
         if (newline || int'(cursor_column) + GLYPH_WIDTH >= COLUMNS) begin
            cursor_page = (cursor_page >= LAST_PAGE) ? 3'd0 : cursor_page + 3'd1;
            cursor_column = 8'd0;
            queue_window();
         end
         if (!newline) begin
            // unprintable codes fall back to the blank glyph
            if (item.code >= CODE_SPACE && item.code <= CODE_LAST_PRINT)
               columns = FONT_ROWS[item.code - CODE_SPACE];
            else
               columns = FONT_ROWS[0];
            for (int i = 0; i < GLYPH_WIDTH; i++)
               queue_byte(columns[39 - 8 * i -: 8], 1'b0);
            queue_byte(SPACER_BYTE, 1'b0);
            cursor_column = cursor_column + 8'(GLYPH_WIDTH + 1);
         end
      end
      if (display_bytes.size() > first)
         display_bytes[$].last = 1'b1;
   endfunction

   task automatic add_print(input logic [7:0] code);
      text_item_type item;
      item.cmd = CMD_PRINT;
      item.code = code;
      item.page = 8'($urandom);
      item.column = 8'($urandom);
      pending_items.push_back(item);
   endtask

   task automatic add_cursor(input logic [7:0] page, input logic [7:0] column);
      text_item_type item;
      item.cmd = CMD_SET_CURSOR;
      item.code = 8'($urandom);
      item.page = page;
      item.column = column;
      pending_items.push_back(item);
   endtask

   // Sender: one beat per accepted item, random gaps, hold while full
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            render_item(pending_items.pop_front());
            items_taken++;
         end
         if (!(req_push && req_full)) begin
            if (push_gap > 0) begin
               push_gap--;
               req_push <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_push <= 1'b1;
               req_cmd <= pending_items[0].cmd;
               req_char_code <= pending_items[0].code;
               req_page_number <= pending_items[0].page;
               req_column_number <= pending_items[0].column;
               if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                  push_gap = $urandom_range(1, 16);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each popped beat against the oldest expected byte
   always @(posedge clock) begin
      display_byte_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (display_bytes.size() == 0) begin
               flag_mismatch($sformatf("unexpected byte %02h", rsp_out_byte));
            end else begin
               want = display_bytes.pop_front();
               if (rsp_out_byte !== want.value)
                  flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                          rsp_out_byte, want.value));
               if (rsp_is_command !== want.is_command)
                  flag_mismatch($sformatf("is_command %b, expected %b",
                                          rsp_is_command, want.is_command));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
            end
         end
         if (receiver_hold) begin
            rsp_pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
               pop_gap = $urandom_range(1, 16);
         end
      end
   end

   // Long back-pressure stretch: the receiver stops popping, so the job queue fills and req_full rises
   initial begin
      wait (items_taken >= 60);
      @(posedge clock);
      receiver_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      receiver_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
   end

   initial begin
      wait (stalled_cycles >= STALL_LIMIT);
      $display("text_to_oled_column_writer_tb: done, errors");
      $finish;
   end

   initial begin
      int pick;
      // directed: glyph extremes, unprintable codes, newline, wraps, bad moves
      add_print(8'h41);
      add_print(8'h20);
      add_print(8'h7E);
      add_print(8'h1F);
      add_print(8'h7F);
      add_print(8'h00);
      add_print(8'hFF);
      add_print(CODE_NEWLINE);
      add_cursor(8'd7, 8'd127);
      add_print(8'h48);
      add_cursor(8'd7, 8'd122);
      add_print(8'h78);
      add_print(8'h79);
      add_cursor(8'd8, 8'd0);
      add_cursor(8'd0, 8'd128);
      add_cursor(8'hFF, 8'hFF);
      add_cursor(8'd0, 8'd0);
      add_print(8'h5F);
      add_cursor(8'd7, 8'd5);
      add_print(CODE_NEWLINE);
      add_print(CODE_NEWLINE);
      add_cursor(8'd3, 8'd121);
      add_print(8'h80);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 68)
            add_print(8'($urandom_range(32, 126)));
         else if (pick < 76)
            add_print(8'($urandom));
         else if (pick < 83)
            add_print(CODE_NEWLINE);
         else if (pick < 89)
            add_cursor(8'($urandom_range(0, LAST_PAGE)), 8'($urandom_range(0, COLUMNS - 1)));
         else if (pick < 95)
            add_cursor(8'($urandom_range(0, LAST_PAGE)),
                       8'($urandom_range(COLUMNS - 10, COLUMNS - 1)));
         else
            add_cursor(8'($urandom), 8'($urandom));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (pending_items.size() == 0 && !req_push);
      wait (display_bytes.size() == 0);
      repeat (20) @(posedge clock);
      if (display_bytes.size() != 0)
         flag_mismatch($sformatf("%0d expected bytes never arrived", display_bytes.size()));
      if (error_count == 0)
         $display("text_to_oled_column_writer_tb: done, clean");
      else
         $display("text_to_oled_column_writer_tb: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/tocw_pkg.sv
hw/rtl/tocw_front.sv
hw/rtl/tocw_queue.sv
hw/rtl/tocw_back.sv
hw/rtl/text_to_oled_column_writer.sv
tb/sv/text_to_oled_column_writer_tb.sv
